/* hw/rtl/gsp_pkg.sv */
// Shared types, codes and helpers for the glyph shelf packer.
`timescale 1ns / 1ps

package gsp_pkg;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 128;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int CRD_W      = 16;
	localparam int PEN_COL_W  = 13;
	localparam int PEN_ROW_W  = 14;
	localparam int UV_W       = 19;

	localparam logic [PEN_COL_W-1:0] PEN_COL_MAX = 13'h1FFF;
	localparam logic [PEN_ROW_W-1:0] PEN_ROW_MAX = 14'h3FFF;
	localparam logic [3:0] MIN_ATLAS_LOG2 = 4'd7;

	localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_LOG2 = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'b1;

	localparam logic [3:0] ATLAS_LOG2_RESET = 4'd10;
	localparam logic [7:0] THRESHOLD_RESET  = 8'd127;

	typedef enum logic {
		KIND_TEX  = 1'b0,
		KIND_RECT = 1'b1
	} kind_t;

	typedef struct packed {
		logic [15:0] glyph_id;
		logic [7:0]  glyph_width;
		logic [7:0]  glyph_rows;
		logic [7:0]  pixel_value;
	} in_t;

	typedef struct packed {
		kind_t            result_kind;
		logic [23:0]      tex_address;
		logic [7:0]       tex_value;
		logic             out_of_atlas;
		logic [15:0]      rect_glyph_id;
		logic [UV_W-1:0]  uv_left;
		logic [UV_W-1:0]  uv_top;
		logic [UV_W-1:0]  uv_right;
		logic [UV_W-1:0]  uv_bottom;
		logic             last_result;
	} res_t;

	// One or two results handed together from the core to the result queue.
	typedef struct packed {
		logic valid;
		logic two;
	} push_t;

	// Scales a texel coordinate to 16 fraction bits of the atlas size and
	// saturates it to the signed result range.
	function automatic logic [UV_W-1:0] uv_scale(input logic signed [17:0] v,
		input logic [3:0] lg);
		logic [4:0]         sh;
		logic signed [27:0] p;
		sh = 5'd16 - {1'b0, lg};
		p = 28'(v) <<< sh;
		if (p > 28'sd262143) begin
			uv_scale = 19'h3FFFF;
		end else if (p < -28'sd262144) begin
			uv_scale = 19'h40000;
		end else begin
			uv_scale = p[UV_W-1:0];
		end
	endfunction

endpackage

/* hw/rtl/gsp_res_fifo.sv */
// Three-entry result queue that takes one or two results per cycle.
`timescale 1ns / 1ps

module gsp_res_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  gsp_pkg::push_t push,
	input  gsp_pkg::res_t  res0,
	input  gsp_pkg::res_t  res1,
	output logic          room,
	output logic          out_valid,
	input  logic          out_ready,
	output gsp_pkg::res_t  head
);
	import gsp_pkg::*;

	res_t       mem_q [3];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [1:0] count_q;
	logic       pop;

	function automatic logic [1:0] inc3(input logic [1:0] p);
		inc3 = (p == 2'd2) ? 2'd0 : p + 2'd1;
	endfunction

	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign room      = (count_q <= 2'd1);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_q] <= res0;
			if (push.two) begin
				mem_q[inc3(wr_q)] <= res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 2'd0;
			rd_q    <= 2'd0;
			count_q <= 2'd0;
		end else begin
			if (push.valid) begin
				wr_q <= push.two ? inc3(inc3(wr_q)) : inc3(wr_q);
			end
			if (pop) begin
				rd_q <= inc3(rd_q);
			end
			count_q <= count_q + (push.valid ? (push.two ? 2'd2 : 2'd1) : 2'd0)
				- (pop ? 2'd1 : 2'd0);
		end
	end

`ifndef NO_ASSERTIONS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> count_q <= 2'd1)
		else $error("result pushed without room for two");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && !pop) |=> count_q > $past(count_q))
		else $error("queue did not grow on push");
	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push.valid) |=> count_q == $past(count_q) - 2'd1)
		else $error("queue did not shrink on pop");
`endif

endmodule

/* hw/rtl/gsp_core.sv */
// Shelf placement, texel addressing and contour box for one pixel per cycle.
`timescale 1ns / 1ps

module gsp_core #(
	parameter int MAX_ATLAS_LOG2 = 12,
	parameter int GLYPH_DIM_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [gsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gsp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          item_valid,
	input  gsp_pkg::in_t                   item,
	output gsp_pkg::push_t                 push,
	output gsp_pkg::res_t                  res0,
	output gsp_pkg::res_t                  res1
);
	import gsp_pkg::*;

	localparam int DW = GLYPH_DIM_BITS;
	localparam logic [3:0] MAX_LG = 4'(MAX_ATLAS_LOG2);

	logic [3:0]           lg_cfg_q;
	logic [7:0]           thr_q;
	logic [PEN_COL_W-1:0] pen_col_q;
	logic [PEN_ROW_W-1:0] pen_row_q;
	logic [DW-1:0]        shelf_q;
	logic [DW-1:0]        col_q;
	logic [DW-1:0]        row_q;
	logic [DW-1:0]        bmin_c_q;
	logic [DW-1:0]        bmax_c_q;
	logic [DW-1:0]        bmin_r_q;
	logic [DW-1:0]        bmax_r_q;

	logic [3:0]           lg;
	logic [CRD_W-1:0]     size;
	logic [15:0]          wx;
	logic [15:0]          hx;
	logic [DW-1:0]        w;
	logic [DW-1:0]        h;
	logic                 empty;
	logic                 start;
	logic                 new_shelf;
	logic [CRD_W-1:0]     row_sum;
	logic [CRD_W-1:0]     col_sum;
	logic [PEN_COL_W-1:0] pcol_e;
	logic [PEN_ROW_W-1:0] prow_e;
	logic [DW-1:0]        shelf_e;
	logic [DW-1:0]        bmin_c;
	logic [DW-1:0]        bmax_c;
	logic [DW-1:0]        bmin_r;
	logic [DW-1:0]        bmax_r;
	logic                 hit;
	logic [CRD_W-1:0]     c;
	logic [CRD_W-1:0]     r;
	logic                 oob;
	logic [31:0]          addr_full;
	logic [DW:0]          col1;
	logic [DW:0]          row1;
	logic                 col_end;
	logic                 last;
	logic [CRD_W-1:0]     pen_next;

	always_comb begin
		lg = lg_cfg_q;
		if (lg < MIN_ATLAS_LOG2) begin
			lg = MIN_ATLAS_LOG2;
		end
		if (lg > MAX_LG) begin
			lg = MAX_LG;
		end
		size = CRD_W'(1) << lg;

		wx = {8'd0, item.glyph_width};
		hx = {8'd0, item.glyph_rows};
		w  = wx[DW-1:0];
		h  = hx[DW-1:0];
		empty = (w == '0) || (h == '0);
		start = (col_q == '0) && (row_q == '0);

		// A glyph that does not fit the current shelf opens a new one below.
		new_shelf = start && ((CRD_W'(pen_col_q) + CRD_W'(w)) > size);
		row_sum   = CRD_W'(pen_row_q) + CRD_W'(shelf_q);
		if (new_shelf) begin
			pcol_e  = '0;
			prow_e  = (row_sum > CRD_W'(PEN_ROW_MAX)) ? PEN_ROW_MAX : row_sum[PEN_ROW_W-1:0];
			shelf_e = '0;
		end else begin
			pcol_e  = pen_col_q;
			prow_e  = pen_row_q;
			shelf_e = shelf_q;
		end

		bmin_c = start ? w : bmin_c_q;
		bmax_c = start ? '0 : bmax_c_q;
		bmin_r = start ? h : bmin_r_q;
		bmax_r = start ? '0 : bmax_r_q;
		hit = (item.pixel_value >= thr_q);
		if (hit) begin
			if (col_q < bmin_c) bmin_c = col_q;
			if (col_q > bmax_c) bmax_c = col_q;
			if (row_q < bmin_r) bmin_r = row_q;
			if (row_q > bmax_r) bmax_r = row_q;
		end

		c = CRD_W'(pcol_e) + CRD_W'(col_q);
		r = CRD_W'(prow_e) + CRD_W'(row_q);
		oob = (c >= size) || (r >= size);
		addr_full = ({16'd0, r} << lg) + {16'd0, c};

		col1    = {1'b0, col_q} + 1'b1;
		row1    = {1'b0, row_q} + 1'b1;
		col_end = (col1 >= {1'b0, w});
		last    = col_end && (row1 >= {1'b0, h});

		col_sum  = CRD_W'(pcol_e) + CRD_W'(w);
		pen_next = (col_sum > CRD_W'(PEN_COL_MAX)) ? CRD_W'(PEN_COL_MAX) : col_sum;

		res0 = '0;
		res1 = '0;
		if (empty) begin
			res0.result_kind   = KIND_RECT;
			res0.rect_glyph_id = item.glyph_id;
			res0.last_result   = 1'b1;
		end else begin
			res0.result_kind  = KIND_TEX;
			res0.out_of_atlas = oob;
			res0.tex_address  = oob ? 24'd0 : addr_full[23:0];
			res0.tex_value    = oob ? 8'd0 : item.pixel_value;
			res0.last_result  = !last;
		end
		res1.result_kind   = KIND_RECT;
		res1.rect_glyph_id = item.glyph_id;
		res1.uv_left   = uv_scale($signed(18'(pcol_e)) + $signed(18'(bmin_c)) - 18'sd1, lg);
		res1.uv_top    = uv_scale($signed(18'(prow_e)) + $signed(18'(bmin_r)) - 18'sd1, lg);
		res1.uv_right  = uv_scale($signed(18'(pcol_e)) + $signed(18'(bmax_c)) + 18'sd1, lg);
		res1.uv_bottom = uv_scale($signed(18'(prow_e)) + $signed(18'(bmax_r)) + 18'sd1, lg);
		res1.last_result = 1'b1;

		push.valid = item_valid;
		push.two   = item_valid && !empty && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_cfg_q  <= ATLAS_LOG2_RESET;
			thr_q     <= THRESHOLD_RESET;
			pen_col_q <= '0;
			pen_row_q <= '0;
			shelf_q   <= '0;
			col_q     <= '0;
			row_q     <= '0;
			bmin_c_q  <= '0;
			bmax_c_q  <= '0;
			bmin_r_q  <= '0;
			bmax_r_q  <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_ATLAS_LOG2: lg_cfg_q <= cfg_data[3:0];
					CFG_THRESHOLD:  thr_q    <= cfg_data;
					default: ;
				endcase
			end
			if (item_valid) begin
				if (empty) begin
					col_q <= '0;
					row_q <= '0;
				end else begin
					pen_row_q <= prow_e;
					bmin_c_q  <= bmin_c;
					bmax_c_q  <= bmax_c;
					bmin_r_q  <= bmin_r;
					bmax_r_q  <= bmax_r;
					if (last) begin
						pen_col_q <= pen_next[PEN_COL_W-1:0];
						shelf_q   <= (h > shelf_e) ? h : shelf_e;
						col_q     <= '0;
						row_q     <= '0;
					end else begin
						pen_col_q <= pcol_e;
						shelf_q   <= shelf_e;
						if (col_end) begin
							col_q <= '0;
							row_q <= row1[DW-1:0];
						end else begin
							col_q <= col1[DW-1:0];
						end
					end
				end
			end
		end
	end

endmodule

/* hw/rtl/glyph_shelf_packer_bbox.sv */
// Top level of the glyph shelf packer with contour bounding box.
`timescale 1ns / 1ps

// The block takes glyph bitmap pixels in row-major order, one request per
// pixel, and places each glyph on shelves of a square power-of-two atlas.
// Every pixel of a non-empty glyph yields a texture write request; its last
// pixel also yields a rectangle request with the threshold contour box,
// widened by one texel and given in signed fixed point with 16 fraction bits.
// A glyph with zero width or rows yields only a zero rectangle. One pixel is
// accepted per cycle: it goes through an input register, then the placement
// and box logic, and lands in a three-entry result queue. The queue output
// sends one result per cycle while the receiver is ready, so a glyph's last
// pixel gives two results; the input stalls while the queue holds two or
// more results. The configuration port is always ready and should be written
// only while no pixel is in flight. No clearing pass follows reset.
module glyph_shelf_packer_bbox #(
	parameter int MAX_ATLAS_LOG2 = 12,
	parameter int GLYPH_DIM_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Pixel request channel.
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// Fields from bit 0: glyph_id[15:0], glyph_width[23:16], glyph_rows[31:24],
	// pixel_value[39:32].
	input  logic [gsp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// Result request channel.
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// Fields from bit 0: tex_address[23:0], tex_value[31:24], out_of_atlas[32],
	// rect_glyph_id[48:33], uv_left[67:49], uv_top[86:68], uv_right[105:87],
	// uv_bottom[124:106], zero pad[127:125].
	output logic [gsp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// Fields from bit 0: result_kind[0].
	output logic                           m_axis_tuser,
	// last_result: final result caused by a pixel request.
	output logic                           m_axis_tlast,
	// Configuration write channel.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gsp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gsp_pkg::*;

	logic  valid_s1;
	in_t   item_s1;
	logic  room;
	logic  advance;
	logic  accept;
	push_t push;
	res_t  res0;
	res_t  res1;
	res_t  head;

	// The input register moves on whenever the queue can take two results.
	assign advance       = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.glyph_id    <= s_axis_tdata[15:0];
			item_s1.glyph_width <= s_axis_tdata[23:16];
			item_s1.glyph_rows  <= s_axis_tdata[31:24];
			item_s1.pixel_value <= s_axis_tdata[39:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	gsp_core #(
		.MAX_ATLAS_LOG2 (MAX_ATLAS_LOG2),
		.GLYPH_DIM_BITS (GLYPH_DIM_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (advance),
		.item       (item_s1),
		.push       (push),
		.res0       (res0),
		.res1       (res1)
	);

	gsp_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res0      (res0),
		.res1      (res1),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.head      (head)
	);

	// Pack the head result onto the stream, lowest field first.
	assign m_axis_tdata = {3'b000, head.uv_bottom, head.uv_right, head.uv_top,
		head.uv_left, head.rect_glyph_id, head.out_of_atlas, head.tex_value,
		head.tex_address};
	assign m_axis_tuser = head.result_kind;
	assign m_axis_tlast = head.last_result;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the glyph shelf packer with contour bounding box.
`timescale 1ns / 1ps

module tb;
	import gsp_pkg::*;

	localparam int ATLAS_LOG2_CEIL = 12;
	localparam int QUIET_LIMIT     = 4000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int RUN_ITEMS       = 30;

	typedef enum int {
		IDLE_NONE,
		IDLE_SRC,
		IDLE_SINK,
		IDLE_BOTH
	} idle_mode_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	glyph_shelf_packer_bbox dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of the configuration and of the packer state.
	logic [3:0] atlas_log2 = ATLAS_LOG2_RESET;
	logic [7:0] threshold  = THRESHOLD_RESET;
	int         pen_col    = 0;
	int         pen_row    = 0;
	int         shelf_h    = 0;
	logic [7:0] pix_col    = '0;
	logic [7:0] pix_row    = '0;
	int         box_min_col = 0;
	int         box_max_col = 0;
	int         box_min_row = 0;
	int         box_max_row = 0;

	in_t  pixel_q[$];
	res_t atlas_results_q[$];
	in_t  bus_item;
	bit   on_bus         = 1'b0;
	int   src_idle_pct   = 0;
	int   sink_stall_pct = 0;
	int   errors         = 0;
	int   quiet_cycles   = 0;
	res_t got;
	res_t want;

	// Scales a signed texel coordinate to 16 fraction bits of the atlas and
	// clamps it to the 19-bit signed range.
	function automatic logic [UV_W-1:0] texel_to_uv(input longint v, input int unsigned lg);
		longint p;
		p = v * (longint'(1) << (16 - lg));
		if (p > 262143) begin
			p = 262143;
		end else if (p < -262144) begin
			p = -262144;
		end
		return p[UV_W-1:0];
	endfunction

	// Works out the texture write and, at a glyph's end, the rectangle that
	// one accepted pixel request causes.
	task automatic pack_pixel(input in_t it);
		int unsigned w, h, lg, atlas_w, col, row;
		bit          is_last;
		res_t        tex, rect;
		w = 32'(it.glyph_width);
		h = 32'(it.glyph_rows);
		lg = 32'(atlas_log2);
		if (lg < MIN_ATLAS_LOG2) lg = 32'(MIN_ATLAS_LOG2);
		if (lg > ATLAS_LOG2_CEIL) lg = ATLAS_LOG2_CEIL;
		atlas_w = 1 << lg;
		tex = '0;
		rect = '0;
		rect.result_kind = KIND_RECT;
		rect.rect_glyph_id = it.glyph_id;
		rect.last_result = 1'b1;
		if (w == 0 || h == 0) begin
			// An empty glyph drops any glyph in progress but keeps the pen.
			atlas_results_q = {atlas_results_q, rect};
			pix_col = '0;
			pix_row = '0;
		end else begin
			if (pix_col == 0 && pix_row == 0) begin
				if (pen_col + w > atlas_w) begin
					pen_col = 0;
					pen_row = pen_row + shelf_h;
					if (pen_row > PEN_ROW_MAX) pen_row = int'(PEN_ROW_MAX);
					shelf_h = 0;
				end
				box_min_col = w;
				box_max_col = 0;
				box_min_row = h;
				box_max_row = 0;
			end
			col = pen_col + pix_col;
			row = pen_row + pix_row;
			tex.result_kind = KIND_TEX;
			if (col >= atlas_w || row >= atlas_w) begin
				tex.out_of_atlas = 1'b1;
			end else begin
				tex.tex_address = 24'((row << lg) + col);
				tex.tex_value = it.pixel_value;
			end
			if (it.pixel_value >= threshold) begin
				if (pix_col < box_min_col) box_min_col = 32'(pix_col);
				if (pix_col > box_max_col) box_max_col = 32'(pix_col);
				if (pix_row < box_min_row) box_min_row = 32'(pix_row);
				if (pix_row > box_max_row) box_max_row = 32'(pix_row);
			end
			is_last = (pix_col + 1 >= w) && (pix_row + 1 >= h);
			tex.last_result = !is_last;
			atlas_results_q = {atlas_results_q, tex};
			if (!is_last) begin
				if (pix_col + 1 >= w) begin
					pix_col = '0;
					pix_row = pix_row + 8'd1;
				end else begin
					pix_col = pix_col + 8'd1;
				end
			end else begin
				// The box is widened by one texel; an edge at zero gives -1.
				rect.uv_left   = texel_to_uv(longint'(pen_col + box_min_col - 1), lg);
				rect.uv_top    = texel_to_uv(longint'(pen_row + box_min_row - 1), lg);
				rect.uv_right  = texel_to_uv(longint'(pen_col + box_max_col + 1), lg);
				rect.uv_bottom = texel_to_uv(longint'(pen_row + box_max_row + 1), lg);
				atlas_results_q = {atlas_results_q, rect};
				pen_col = pen_col + w;
				if (pen_col > PEN_COL_MAX) pen_col = int'(PEN_COL_MAX);
				if (h > shelf_h) shelf_h = h;
				pix_col = '0;
				pix_row = '0;
			end
		end
	endtask

	task automatic check_field(input string name, input longint unsigned exp_v,
		input longint unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// Pixel request driver: valid stays up until the request is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				pack_pixel(bus_item);
				on_bus = 1'b0;
			end
			if (!on_bus && pixel_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				bus_item = pixel_q.pop_front();
				on_bus = 1'b1;
				s_axis_tdata <= {bus_item.pixel_value, bus_item.glyph_rows,
					bus_item.glyph_width, bus_item.glyph_id};
				s_axis_tvalid <= 1'b1;
			end else if (!on_bus) begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result monitor and receiver stall generator.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.result_kind   = kind_t'(m_axis_tuser);
				got.tex_address   = m_axis_tdata[23:0];
				got.tex_value     = m_axis_tdata[31:24];
				got.out_of_atlas  = m_axis_tdata[32];
				got.rect_glyph_id = m_axis_tdata[48:33];
				got.uv_left       = m_axis_tdata[67:49];
				got.uv_top        = m_axis_tdata[86:68];
				got.uv_right      = m_axis_tdata[105:87];
				got.uv_bottom     = m_axis_tdata[124:106];
				got.last_result   = m_axis_tlast;
				if (atlas_results_q.size() == 0) begin
					$error("result with nothing expected: kind %0d data %0h",
						m_axis_tuser, m_axis_tdata);
					errors++;
				end else begin
					want = atlas_results_q.pop_front();
					check_field("result_kind", want.result_kind, got.result_kind);
					check_field("tex_address", want.tex_address, got.tex_address);
					check_field("tex_value", want.tex_value, got.tex_value);
					check_field("out_of_atlas", want.out_of_atlas, got.out_of_atlas);
					check_field("rect_glyph_id", want.rect_glyph_id, got.rect_glyph_id);
					check_field("uv_left", want.uv_left, got.uv_left);
					check_field("uv_top", want.uv_top, got.uv_top);
					check_field("uv_right", want.uv_right, got.uv_right);
					check_field("uv_bottom", want.uv_bottom, got.uv_bottom);
					check_field("last_result", want.last_result, got.last_result);
				end
			end
			m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Any handshake on any channel counts as progress.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_ATLAS_LOG2) begin
			atlas_log2 = val[3:0];
		end else begin
			threshold = val;
		end
	endtask

	// Waits until every request has been taken and every result has come.
	task automatic wait_quiet();
		while (pixel_q.size() != 0 || on_bus || atlas_results_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_item(input logic [15:0] id, input logic [7:0] w, input logic [7:0] h,
		input logic [7:0] px);
		in_t it;
		it.glyph_id = id;
		it.glyph_width = w;
		it.glyph_rows = h;
		it.pixel_value = px;
		pixel_q = {pixel_q, it};
	endtask

	// Samples cluster around the threshold so both sides of it are hit.
	function automatic logic [7:0] pick_pixel();
		logic [7:0] px;
		case ($urandom_range(3))
			0: px = threshold;
			1: px = threshold - 8'd1;
			2: px = $urandom_range(1) ? 8'hFF : 8'h00;
			default: px = 8'($urandom);
		endcase
		return px;
	endfunction

	// Queues the first count pixels of a glyph in row-major order.
	task automatic queue_glyph(input logic [15:0] id, input int w, input int h, input int count);
		for (int k = 0; k < count; k++) begin
			queue_item(id, 8'(w), 8'(h), pick_pixel());
		end
	endtask

	task automatic queue_random_run(input int n);
		int          queued, w, h, count, pick;
		logic [15:0] id;
		queued = 0;
		while (queued < n) begin
			id = 16'($urandom);
			pick = $urandom_range(99);
			if (pick < 8) begin
				// Empty glyph, with the other dimension anywhere in range.
				if ($urandom_range(1)) begin
					queue_item(id, 8'd0, 8'($urandom), 8'($urandom));
				end else begin
					queue_item(id, 8'($urandom), 8'd0, 8'($urandom));
				end
				queued++;
			end else if (pick < 14) begin
				// A lone pixel whose dimensions may differ from the glyph in progress.
				queue_item(id, 8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
					pick_pixel());
				queued++;
			end else begin
				if (pick < 17) begin
					w = $urandom_range(129, 255);
					h = 1;
				end else if (pick < 22) begin
					w = 1;
					h = $urandom_range(16, 48);
				end else if (pick < 40) begin
					w = $urandom_range(1, 16);
					h = $urandom_range(1, 16);
				end else begin
					w = $urandom_range(1, 6);
					h = $urandom_range(1, 6);
				end
				// Now and then a glyph is cut short and the next one runs on from it.
				count = ($urandom_range(99) < 12) ? $urandom_range(1, w * h) : w * h;
				// The run stops at n requests, so its last glyph may be cut short too.
				if (count > n - queued) count = n - queued;
				queue_glyph(id, w, h, count);
				queued += count;
			end
		end
	endtask

	task automatic run_phase(input logic [3:0] lg, input logic [7:0] thr, input idle_mode_t mode);
		write_reg(CFG_ATLAS_LOG2, {4'($urandom), lg});
		write_reg(CFG_THRESHOLD, thr);
		case (mode)
			IDLE_NONE: begin
				src_idle_pct = 0;
				sink_stall_pct = 0;
			end
			IDLE_SRC: begin
				src_idle_pct = 72;
				sink_stall_pct = 0;
			end
			IDLE_SINK: begin
				src_idle_pct = 0;
				sink_stall_pct = 72;
			end
			default: begin
				src_idle_pct = 8;
				sink_stall_pct = 8;
			end
		endcase
		queue_random_run(RUN_ITEMS);
		wait_quiet();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset settings, with no idling.
		queue_item(16'hFFFF, 8'd0, 8'd255, 8'h00);
		queue_item(16'h0000, 8'd255, 8'd0, 8'hFF);
		// Small glyph with samples on and right around the threshold.
		queue_item(16'h1234, 8'd2, 8'd2, 8'd0);
		queue_item(16'h1234, 8'd2, 8'd2, 8'd255);
		queue_item(16'h1234, 8'd2, 8'd2, 8'd127);
		queue_item(16'h1234, 8'd2, 8'd2, 8'd126);
		// No pixel inside: the box keeps its start values.
		queue_item(16'h0100, 8'd3, 8'd1, 8'd10);
		queue_item(16'h0100, 8'd3, 8'd1, 8'd20);
		queue_item(16'h0100, 8'd3, 8'd1, 8'd30);
		// Dimensions shrink mid-glyph, so the second pixel ends it.
		queue_item(16'h0042, 8'd2, 8'd2, 8'd200);
		queue_item(16'h0042, 8'd1, 8'd1, 8'd130);
		// An empty glyph abandons the glyph in progress.
		queue_item(16'h0007, 8'd3, 8'd3, 8'd128);
		queue_item(16'h0007, 8'd3, 8'd3, 8'd129);
		queue_item(16'h0007, 8'd0, 8'd3, 8'd0);
		queue_item(16'h0008, 8'd1, 8'd1, 8'd255);
		wait_quiet();

		// Out-of-range sizes 0 and 15 must clamp to 7 and 12.
		run_phase(4'd7, 8'd127, IDLE_NONE);
		run_phase(4'd12, 8'd0, IDLE_SRC);
		run_phase(4'd0, 8'd255, IDLE_SINK);
		run_phase(4'd15, 8'($urandom), IDLE_BOTH);
		run_phase(4'd8, 8'($urandom), IDLE_NONE);
		run_phase(4'd9, 8'd200, IDLE_SRC);
		run_phase(4'd11, 8'd1, IDLE_SINK);
		run_phase(4'd10, 8'($urandom), IDLE_BOTH);

		// Tall narrow glyphs, each opened by a pixel wider than the 128-texel
		// atlas so that it starts a new shelf, stack shelves until texels fall
		// off the bottom of the atlas.
		write_reg(CFG_ATLAS_LOG2, 8'd7);
		write_reg(CFG_THRESHOLD, 8'd0);
		src_idle_pct = 8;
		sink_stall_pct = 8;
		queue_item(16'($urandom), 8'd0, 8'd0, 8'd0);
		for (int g = 0; g < 3; g++) begin
			queue_item(16'(16'h0200 + g), 8'd200, 8'd48, pick_pixel());
			queue_glyph(16'(16'h0200 + g), 1, 48, 48);
		end
		wait_quiet();

		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
